// ===== rtl/periodic_task_priority_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PERIODIC_TASK_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a clocked property outside reset.
`define PTPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a condition never holds outside reset.
`define PTPS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTPS_ASSERT(label, prop, msg)
`define PTPS_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/ptps_pkg.sv =====
// Types, codes and constants of the periodic task priority scheduler.
package ptps_pkg;

    // Default table sizes.
    localparam int TASK_SLOTS_DEF      = 8;
    localparam int TICK_TASK_SLOTS_DEF = 8;

    // Priority limits and the value of an unused slot.
    localparam logic [7:0] PRIO_MIN   = 8'd5;
    localparam logic [7:0] PRIO_MAX   = 8'd250;
    localparam logic [7:0] PRIO_RESET = 8'd255;

    // At most this many fired tick tasks are reported per tick.
    localparam int RESULT_LIMIT = 8;
    localparam int FIRE_CNT_W   = $clog2(RESULT_LIMIT + 1);

    // Request action codes.
    typedef enum logic [2:0] {
        ACT_CREATE       = 3'd0,
        ACT_DESTROY      = 3'd1,
        ACT_CREATE_TICK  = 3'd2,
        ACT_DESTROY_TICK = 3'd3,
        ACT_TICK         = 3'd4,
        ACT_DISPATCH     = 3'd5
    } action_t;

    // Response kinds.
    typedef enum logic [1:0] {
        KIND_ACK        = 2'd0,
        KIND_DISPATCHED = 2'd1,
        KIND_FIRED      = 2'd2,
        KIND_NONE       = 2'd3
    } kind_t;

    // Request beat.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  task_id;
        logic [15:0] period;
        logic [7:0]  priority_req;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_task_id;
        logic [31:0] tick_count;
        logic        last;
    } rsp_t;

    // One row of the periodic task table.
    typedef struct packed {
        logic        present;
        logic        enabled;
        logic        ready;
        logic [7:0]  prio;
        logic [15:0] countdown;
        logic [15:0] period;
        logic [7:0]  ident;
    } task_entry_t;

    // One row of the tick-time task list.
    typedef struct packed {
        logic        present;
        logic [15:0] countdown;
        logic [15:0] period;
        logic [7:0]  ident;
    } tick_entry_t;

    // Contents of rows that were never written.
    localparam task_entry_t TASK_CLEAR = '{
        present:   1'b0,
        enabled:   1'b0,
        ready:     1'b0,
        prio:      PRIO_RESET,
        countdown: 16'd0,
        period:    16'd0,
        ident:     8'd0
    };

    localparam tick_entry_t TICK_CLEAR = '{
        present:   1'b0,
        countdown: 16'd0,
        period:    16'd0,
        ident:     8'd0
    };

endpackage

// ===== rtl/ptps_ram.sv =====
// Single-port-write, registered-read row memory with per-row written flags.
module ptps_ram #(
    parameter int               DEPTH      = 8,
    parameter int               WIDTH      = 8,
    parameter logic [WIDTH-1:0] CLEAR_WORD = '0,
    localparam int              AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] word_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_word_reg;
    logic             rd_hit_reg;

    // Storage array and its registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= word_mem[rd_addr];
    end

    // A row reads as the clear word until it has been written once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : CLEAR_WORD;

endmodule

// ===== rtl/periodic_task_priority_scheduler_unit.sv =====
// Top level of the periodic task priority scheduler.
// Each slot visited is read (S_RD) and then worked on (S_OP); S_DONE sends the final beat,
// after S_CLR for a tick task removal. One request is worked on at a time: req_ready is
// low until the final beat is sent, and a full response register stalls the walk.
// Reset: rst_n clears the sequencer, tick counter, enable and the memories' written
// flags, so every slot reads as empty and every task table slot with priority 255.
`include "periodic_task_priority_scheduler_unit_assert.svh"

module periodic_task_priority_scheduler_unit
    import ptps_pkg::*;
#(
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF,
    parameter int TICK_TASK_SLOTS = TICK_TASK_SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam int MAX_SLOTS = (TASK_SLOTS > TICK_TASK_SLOTS) ? TASK_SLOTS : TICK_TASK_SLOTS;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int TASK_AW   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int TICK_AW   = (TICK_TASK_SLOTS > 1) ? $clog2(TICK_TASK_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_OP,
        S_CLR,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            act_reg, act_next;
    logic [7:0]            id_reg, id_next;
    logic [15:0]           per_reg, per_next;
    logic [7:0]            prio_reg, prio_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic                  on_tick_reg, on_tick_next;
    logic                  shift_reg, shift_next;
    task_entry_t           carry_reg, carry_next;
    kind_t                 fin_kind_reg, fin_kind_next;
    logic [7:0]            fin_id_reg, fin_id_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic                  enable_reg, enable_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    logic                  task_we;
    logic [TASK_AW-1:0]    task_waddr;
    task_entry_t           task_wdata;
    task_entry_t           task_rd;
    logic                  tick_we;
    logic [TICK_AW-1:0]    tick_waddr;
    tick_entry_t           tick_wdata;
    tick_entry_t           tick_rd;

    logic [IDX_W-1:0]      k_prev;
    logic                  task_last;
    logic                  tick_last;
    logic                  out_free;
    logic [7:0]            prio_clamped;
    task_entry_t           task_new;
    task_entry_t           task_upd;
    tick_entry_t           tick_new;
    tick_entry_t           tick_upd;
    logic                  tick_fires;
    logic                  report;
    logic                  push;

    // Slot memories.
    ptps_ram #(
        .DEPTH      (TASK_SLOTS),
        .WIDTH      ($bits(task_entry_t)),
        .CLEAR_WORD (TASK_CLEAR)
    ) u_task_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (task_we),
        .wr_addr (task_waddr),
        .wr_data (task_wdata),
        .rd_addr (k_reg[TASK_AW-1:0]),
        .rd_data (task_rd)
    );

    ptps_ram #(
        .DEPTH      (TICK_TASK_SLOTS),
        .WIDTH      ($bits(tick_entry_t)),
        .CLEAR_WORD (TICK_CLEAR)
    ) u_tick_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tick_we),
        .wr_addr (tick_waddr),
        .wr_data (tick_wdata),
        .rd_addr (k_reg[TICK_AW-1:0]),
        .rd_data (tick_rd)
    );

    // Handshake outputs.
    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Walk position helpers.
    assign k_prev    = k_reg - IDX_W'(1);
    assign task_last = (k_reg == IDX_W'(TASK_SLOTS - 1));
    assign tick_last = (k_reg == IDX_W'(TICK_TASK_SLOTS - 1));

    // Requested priority limited to the legal range.
    always_comb
    begin
        priority if (req_data.priority_req < PRIO_MIN)
        begin
            prio_clamped = PRIO_MIN;
        end
        else if (req_data.priority_req > PRIO_MAX)
        begin
            prio_clamped = PRIO_MAX;
        end
        else
        begin
            prio_clamped = req_data.priority_req;
        end
    end

    // New rows for the create actions.
    always_comb
    begin
        task_new = '{
            present:   1'b1,
            enabled:   1'b1,
            ready:     1'b0,
            prio:      prio_reg,
            countdown: per_reg,
            period:    per_reg,
            ident:     id_reg
        };
        tick_new = '{
            present:   1'b1,
            countdown: per_reg,
            period:    per_reg,
            ident:     id_reg
        };
    end

    // Countdown update of the rows read during a tick.
    always_comb
    begin
        task_upd = task_rd;
        if (task_rd.enabled && task_rd.countdown != 16'd0)
        begin
            task_upd.countdown = task_rd.countdown - 16'd1;
            if (task_rd.countdown == 16'd1)
            begin
                task_upd.countdown = task_rd.period;
                task_upd.ready     = 1'b1;
            end
        end
        tick_upd   = tick_rd;
        tick_fires = (tick_rd.countdown == 16'd1);
        if (tick_rd.countdown != 16'd0)
        begin
            tick_upd.countdown = tick_rd.countdown - 16'd1;
            if (tick_fires)
            begin
                tick_upd.countdown = tick_rd.period;
            end
        end
        report = tick_fires && (fire_cnt_reg < FIRE_CNT_W'(RESULT_LIMIT));
        push   = report && (fin_kind_reg == KIND_FIRED);
    end

    // Sequencer: one slot is read, then modified and written back.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        per_next       = per_reg;
        prio_next      = prio_reg;
        k_next         = k_reg;
        on_tick_next   = on_tick_reg;
        shift_next     = shift_reg;
        carry_next     = carry_reg;
        fin_kind_next  = fin_kind_reg;
        fin_id_next    = fin_id_reg;
        fire_cnt_next  = fire_cnt_reg;
        ticks_next     = ticks_reg;
        enable_next    = enable_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        task_we        = 1'b0;
        task_waddr     = k_reg[TASK_AW-1:0];
        task_wdata     = task_rd;
        tick_we        = 1'b0;
        tick_waddr     = k_reg[TICK_AW-1:0];
        tick_wdata     = tick_rd;

        if (cfg_valid)
        begin
            enable_next = cfg_data;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next      = req_data.action;
                    id_next       = req_data.task_id;
                    per_next      = req_data.period;
                    prio_next     = prio_clamped;
                    k_next        = '0;
                    on_tick_next  = 1'b0;
                    shift_next    = 1'b0;
                    fire_cnt_next = '0;
                    fin_id_next   = 8'd0;
                    fin_kind_next = KIND_ACK;
                    unique case (req_data.action)
                        ACT_CREATE, ACT_DESTROY:
                        begin
                            state_next = S_RD;
                        end
                        ACT_CREATE_TICK, ACT_DESTROY_TICK:
                        begin
                            on_tick_next = 1'b1;
                            state_next   = S_RD;
                        end
                        ACT_TICK:
                        begin
                            if (enable_reg)
                            begin
                                ticks_next = ticks_reg + 32'd1;
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        ACT_DISPATCH:
                        begin
                            fin_kind_next = KIND_NONE;
                            state_next    = S_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                state_next = S_OP;
            end

            S_OP:
            begin
                unique case (act_reg)
                    ACT_CREATE:
                    begin
                        // Insert before the first row of equal or lower urgency; a disabled row there is
                        // overwritten, else the displaced rows ripple down, dropping the last one.
                        if (shift_reg)
                        begin
                            task_we    = 1'b1;
                            task_wdata = carry_reg;
                            carry_next = task_rd;
                            state_next = task_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                        else if (task_rd.prio >= prio_reg)
                        begin
                            task_we    = 1'b1;
                            task_wdata = task_new;
                            if (task_rd.enabled)
                            begin
                                shift_next = 1'b1;
                                carry_next = task_rd;
                                state_next = task_last ? S_DONE : S_RD;
                                k_next     = k_reg + IDX_W'(1);
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        else
                        begin
                            state_next = task_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    ACT_DESTROY:
                    begin
                        if (task_rd.present && task_rd.ident == id_reg)
                        begin
                            task_we            = 1'b1;
                            task_wdata.enabled = 1'b0;
                            state_next         = S_DONE;
                        end
                        else
                        begin
                            state_next = task_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    ACT_CREATE_TICK:
                    begin
                        if (!tick_rd.present)
                        begin
                            tick_we    = 1'b1;
                            tick_wdata = tick_new;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = tick_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    ACT_DESTROY_TICK:
                    begin
                        // After the match every row moves up one place.
                        if (shift_reg)
                        begin
                            tick_we    = 1'b1;
                            tick_waddr = k_prev[TICK_AW-1:0];
                        end
                        shift_next = shift_reg || (tick_rd.present && tick_rd.ident == id_reg);
                        if (tick_last)
                        begin
                            state_next = shift_next ? S_CLR : S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    ACT_TICK:
                    begin
                        if (!on_tick_reg)
                        begin
                            // Periodic table: count down and mark expired tasks ready.
                            if (task_rd.present)
                            begin
                                task_we    = 1'b1;
                                task_wdata = task_upd;
                            end
                            if (!task_rd.present || task_last)
                            begin
                                on_tick_next = 1'b1;
                                k_next       = '0;
                            end
                            else
                            begin
                                k_next = k_reg + IDX_W'(1);
                            end
                            state_next = S_RD;
                        end
                        else if (!tick_rd.present)
                        begin
                            state_next = S_DONE;
                        end
                        else if (!(push && !out_free))
                        begin
                            // Tick list: the newest fire is held back so the final
                            // beat can carry the last flag.
                            tick_we    = 1'b1;
                            tick_wdata = tick_upd;
                            if (push)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_data_next  = '{
                                    kind:        fin_kind_reg,
                                    out_task_id: fin_id_reg,
                                    tick_count:  ticks_reg,
                                    last:        1'b0
                                };
                            end
                            if (report)
                            begin
                                fin_kind_next = KIND_FIRED;
                                fin_id_next   = tick_rd.ident;
                                fire_cnt_next = fire_cnt_reg + FIRE_CNT_W'(1);
                            end
                            state_next = tick_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    ACT_DISPATCH:
                    begin
                        if (!task_rd.present)
                        begin
                            state_next = S_DONE;
                        end
                        else if (task_rd.enabled && task_rd.ready)
                        begin
                            task_we          = 1'b1;
                            task_wdata.ready = 1'b0;
                            fin_kind_next    = KIND_DISPATCHED;
                            fin_id_next      = task_rd.ident;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            state_next = task_last ? S_DONE : S_RD;
                            k_next     = k_reg + IDX_W'(1);
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CLR:
            begin
                // The vacated last row of the tick list is cleared.
                tick_we    = 1'b1;
                tick_waddr = TICK_AW'(TICK_TASK_SLOTS - 1);
                tick_wdata = TICK_CLEAR;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '{
                        kind:        fin_kind_reg,
                        out_task_id: fin_id_reg,
                        tick_count:  ticks_reg,
                        last:        1'b1
                    };
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= '0;
            id_reg        <= '0;
            per_reg       <= '0;
            prio_reg      <= '0;
            k_reg         <= '0;
            on_tick_reg   <= 1'b0;
            shift_reg     <= 1'b0;
            carry_reg     <= TASK_CLEAR;
            fin_kind_reg  <= KIND_ACK;
            fin_id_reg    <= '0;
            fire_cnt_reg  <= '0;
            ticks_reg     <= '0;
            enable_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            id_reg        <= id_next;
            per_reg       <= per_next;
            prio_reg      <= prio_next;
            k_reg         <= k_next;
            on_tick_reg   <= on_tick_next;
            shift_reg     <= shift_next;
            carry_reg     <= carry_next;
            fin_kind_reg  <= fin_kind_next;
            fin_id_reg    <= fin_id_next;
            fire_cnt_reg  <= fire_cnt_next;
            ticks_reg     <= ticks_next;
            enable_reg    <= enable_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // An accepted request always starts a walk or a final beat.
    `PTPS_ASSERT(a_leave_idle, (req_valid && req_ready) |=> !req_ready, "request taken twice")
    // Memories are written only while a request is being worked on.
    `PTPS_ASSERT_NEVER(a_idle_write, state_reg == S_IDLE && (task_we || tick_we), "idle write")
    // No more fires are reported than the result limit allows.
    `PTPS_ASSERT_NEVER(a_fire_limit, fire_cnt_reg > FIRE_CNT_W'(RESULT_LIMIT), "fire count overrun")

endmodule
